/* design/ansp_pkg.sv */
// Shared types, constants and header field decoders for the Annex B NAL splitter.
`default_nettype none

package ansp_pkg;

  // Most results that one input byte can release at once.
  localparam int RES_DEPTH = 5;

  typedef logic [2:0] res_cnt_t;

  // Saturating count of confirmed bytes in the current NAL unit.
  typedef enum logic [1:0] {
    LEN_NONE = 2'd0,
    LEN_ONE  = 2'd1,
    LEN_TWO  = 2'd2
  } unit_len_t;

  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [1:0] ZERO_RUN_MAX = 2'd3;
  localparam logic [1:0] ZERO_RUN_SC3 = 2'd2;

  // Scanner state carried from byte to byte.
  typedef struct packed {
    logic       in_nal;
    logic [1:0] zero_run;
    unit_len_t  unit_len;
    logic [7:0] held_byte;
    logic [15:0] header_word;
  } scan_t;

  // One result byte together with the header it belongs to.
  typedef struct packed {
    logic [7:0]  nal_byte;
    logic        first_of_nal;
    logic        end_of_nal;
    logic [15:0] header_word;
  } res_t;

  function automatic logic [5:0] hdr_unit_type(logic [15:0] hdr);
    return hdr[14:9];
  endfunction

  function automatic logic [5:0] hdr_layer(logic [15:0] hdr);
    return {hdr[8], hdr[7:3]};
  endfunction

  function automatic logic signed [3:0] hdr_temporal(logic [15:0] hdr);
    return $signed({1'b0, hdr[2:0]} + 4'hF);
  endfunction

endpackage

`default_nettype wire

/* design/ansp_step.sv */
// Start code scanner: next state and released result bytes for one input byte.
`default_nettype none

module ansp_step (
  input  ansp_pkg::scan_t    scan_cur,
  input  logic [7:0]         byte_value,
  input  logic               end_of_buffer,
  output ansp_pkg::scan_t    scan_nxt,
  output ansp_pkg::res_t     res_list [ansp_pkg::RES_DEPTH],
  output ansp_pkg::res_cnt_t res_cnt
);
  import ansp_pkg::*;

  typedef struct packed {
    scan_t st;
    logic  emit;
    res_t  res;
  } conf_t;

  // Confirm one data byte: the previously held byte, if there is one, becomes a result.
  function automatic conf_t confirm_byte(scan_t s, logic [7:0] b);
    conf_t c;
    c.st   = s;
    c.emit = 1'b0;
    c.res  = '0;
    unique case (s.unit_len)
      LEN_NONE: begin
        c.st.header_word = {b, 8'h00};
        c.st.held_byte   = b;
        c.st.unit_len    = LEN_ONE;
      end
      LEN_ONE: begin
        c.st.header_word = {s.header_word[15:8], b};
        c.emit           = 1'b1;
        c.res            = '{nal_byte: s.held_byte, first_of_nal: 1'b1, end_of_nal: 1'b0,
                             header_word: c.st.header_word};
        c.st.held_byte   = b;
        c.st.unit_len    = LEN_TWO;
      end
      default: begin
        c.emit         = 1'b1;
        c.res          = '{nal_byte: s.held_byte, first_of_nal: 1'b0, end_of_nal: 1'b0,
                           header_word: s.header_word};
        c.st.held_byte = b;
      end
    endcase
    return c;
  endfunction

  // Close the unit: the held byte is its last byte if the unit is long enough.
  function automatic conf_t finish_unit(scan_t s);
    conf_t c;
    c.st   = s;
    c.emit = (s.unit_len == LEN_TWO);
    c.res  = '{nal_byte: s.held_byte, first_of_nal: 1'b0, end_of_nal: 1'b1,
               header_word: s.header_word};
    c.st.unit_len    = LEN_NONE;
    c.st.header_word = '0;
    c.st.held_byte   = '0;
    return c;
  endfunction

  scan_t    s;
  conf_t    c;
  res_cnt_t n;
  logic     code;

  // Walk the byte through the scanner, appending each released result.
  always_comb begin
    s    = scan_cur;
    n    = '0;
    c    = '0;
    for (int i = 0; i < RES_DEPTH; i++) begin
      res_list[i] = '0;
    end
    code = (byte_value == START_BYTE) && (s.zero_run >= ZERO_RUN_SC3) &&
           !(end_of_buffer && (s.zero_run == ZERO_RUN_SC3));

    if (s.in_nal) begin
      if (byte_value == 8'h00) begin
        if (s.zero_run == ZERO_RUN_MAX) begin
          c = confirm_byte(s, 8'h00);
          s = c.st;
          if (c.emit) begin
            res_list[n] = c.res;
            n = n + res_cnt_t'(1);
          end
        end else begin
          s.zero_run = s.zero_run + 2'd1;
        end
      end else if (code) begin
        c = finish_unit(s);
        s = c.st;
        if (c.emit) begin
          res_list[n] = c.res;
          n = n + res_cnt_t'(1);
        end
        s.zero_run = '0;
      end else begin
        // Pending zeros turned out to be data.
        for (int i = 0; i < 3; i++) begin
          if (s.zero_run != 2'd0) begin
            c = confirm_byte(s, 8'h00);
            s = c.st;
            if (c.emit) begin
              res_list[n] = c.res;
              n = n + res_cnt_t'(1);
            end
            s.zero_run = s.zero_run - 2'd1;
          end
        end
        c = confirm_byte(s, byte_value);
        s = c.st;
        if (c.emit) begin
          res_list[n] = c.res;
          n = n + res_cnt_t'(1);
        end
      end

      // Final byte of the buffer: release everything still held.
      if (end_of_buffer) begin
        for (int i = 0; i < 3; i++) begin
          if (s.zero_run != 2'd0) begin
            c = confirm_byte(s, 8'h00);
            s = c.st;
            if (c.emit) begin
              res_list[n] = c.res;
              n = n + res_cnt_t'(1);
            end
            s.zero_run = s.zero_run - 2'd1;
          end
        end
        c = finish_unit(s);
        s = c.st;
        if (c.emit) begin
          res_list[n] = c.res;
          n = n + res_cnt_t'(1);
        end
      end
    end else begin
      // Searching for the first start code.
      if (byte_value == 8'h00) begin
        if (s.zero_run != ZERO_RUN_MAX) begin
          s.zero_run = s.zero_run + 2'd1;
        end
      end else if (code) begin
        s.in_nal   = 1'b1;
        s.unit_len = LEN_NONE;
        s.zero_run = '0;
      end else begin
        s.zero_run = '0;
      end
    end

    if (end_of_buffer) begin
      s = '0;
    end

    scan_nxt = s;
    res_cnt  = n;
  end

endmodule

`default_nettype wire

/* design/annexb_nal_splitter.sv */
// The first result of a byte is registered and appears on the output in the cycle after its input transaction.
// Throughput: one byte per cycle while each byte releases at most one result and out_tready stays high.
// A byte that releases k results (up to five) holds the input while the result queue drains them,
// one result per cycle while out_tready is high, until the last of them leaves.
// Reset (rst_n low, synchronous) returns the scanner to searching and empties the queue.
`default_nettype none

module annexb_nal_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // end_of_buffer
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] nal_byte, [13:8] unit_type,
                                  // [19:14] layer_number, [23:20] temporal_level
  output logic        out_tuser,  // first_of_nal
  output logic        out_tlast   // end_of_nal
);
  import ansp_pkg::*;

  scan_t    scan_r;
  scan_t    scan_nxt;
  res_t     step_res [RES_DEPTH];
  res_cnt_t step_cnt;
  res_t     queue_r  [RES_DEPTH];
  res_cnt_t cnt_r;
  logic     in_fire;
  logic     out_fire;

  ansp_step u_step (
    .scan_cur      (scan_r),
    .byte_value    (in_tdata),
    .end_of_buffer (in_tlast),
    .scan_nxt      (scan_nxt),
    .res_list      (step_res),
    .res_cnt       (step_cnt)
  );

  // Take a byte when the queue is empty or its last result leaves this cycle.
  assign out_fire  = out_tvalid && out_tready;
  assign in_tready = (cnt_r == res_cnt_t'(0)) || ((cnt_r == res_cnt_t'(1)) && out_tready);
  assign in_fire   = in_tvalid && in_tready;

  // Scanner state advances on every input transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else if (in_fire) begin
      scan_r <= scan_nxt;
    end
  end

  // Result queue count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_fire) begin
      cnt_r <= step_cnt;
    end else if (out_fire) begin
      cnt_r <= cnt_r - res_cnt_t'(1);
    end
  end

  // Result queue payload: load a new batch or shift toward the head.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < RES_DEPTH; i++) begin
        queue_r[i] <= step_res[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < RES_DEPTH - 1; i++) begin
        queue_r[i] <= queue_r[i + 1];
      end
    end
  end

  // Head of the queue drives the output transaction.
  assign out_tvalid = (cnt_r != res_cnt_t'(0));
  assign out_tdata  = {hdr_temporal(queue_r[0].header_word),
                       hdr_layer(queue_r[0].header_word),
                       hdr_unit_type(queue_r[0].header_word),
                       queue_r[0].nal_byte};
  assign out_tuser  = queue_r[0].first_of_nal;
  assign out_tlast  = queue_r[0].end_of_nal;

endmodule

`default_nettype wire

/* sim/nal_sb_pkg.sv */
// Scoreboard package for the Annex B NAL splitter testbench: result types and the checker class.
`default_nettype none

package nal_sb_pkg;

  import ansp_pkg::*;

  // One input byte as the stimulus driver holds it.
  typedef struct {
    logic [7:0] byte_value;
    logic       end_of_buffer;
  } stream_byte_t;

  // One expected output transaction, split into its fields.
  typedef struct packed {
    logic [7:0] nal_byte;
    logic       first_of_nal;
    logic       end_of_nal;
    logic [5:0] unit_type;
    logic [5:0] layer_number;
    logic [3:0] temporal_level;
  } nal_result_t;

  class nal_scoreboard;

    // Scanner state, mirrored from the block's behavior.
    logic        in_unit;
    logic [1:0]  pending_zeros;
    unit_len_t   unit_len;
    logic [7:0]  held_byte;
    logic [15:0] hdr;

    nal_result_t expected_bytes[$];
    int          mismatches;

    function new();
      in_unit       = 1'b0;
      pending_zeros = '0;
      unit_len      = LEN_NONE;
      held_byte     = '0;
      hdr           = '0;
      mismatches    = 0;
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction

    // Queue one NAL byte, tagged with the fields of the current header.
    function void release_byte(logic [7:0] b, logic first, logic last);
      nal_result_t r;
      logic [7:0]  h0;
      logic [7:0]  h1;
      h0 = hdr[15:8];
      h1 = hdr[7:0];
      r.nal_byte       = b;
      r.first_of_nal   = first;
      r.end_of_nal     = last;
      r.unit_type      = h0[6:1];
      r.layer_number   = {h0[0], h1[7:3]};
      r.temporal_level = {1'b0, h1[2:0]} - 4'd1;
      expected_bytes = {expected_bytes, r};
    endfunction

    // A byte is known to be data; the one held before it, if any, can now go out.
    function void accept_data(logic [7:0] b);
      case (unit_len)
        LEN_NONE: begin
          hdr       = {b, 8'h00};
          held_byte = b;
          unit_len  = LEN_ONE;
        end
        LEN_ONE: begin
          hdr[7:0] = b;
          release_byte(held_byte, 1'b1, 1'b0);
          held_byte = b;
          unit_len  = LEN_TWO;
        end
        default: begin
          release_byte(held_byte, 1'b0, 1'b0);
          held_byte = b;
        end
      endcase
    endfunction

    // End of a unit: the held byte carries the end mark, short units vanish.
    function void close_unit();
      if (unit_len == LEN_TWO) begin
        release_byte(held_byte, 1'b0, 1'b1);
      end
      unit_len  = LEN_NONE;
      hdr       = '0;
      held_byte = '0;
    endfunction

    function void flush_pending_zeros();
      while (pending_zeros > 0) begin
        accept_data(8'h00);
        pending_zeros = pending_zeros - 2'd1;
      end
    endfunction

    // Predict the output transactions caused by one accepted input byte.
    function void note_input(logic [7:0] b, logic last);
      logic is_code;
      is_code = (b == START_BYTE) && (pending_zeros >= ZERO_RUN_SC3) &&
                !(last && pending_zeros == ZERO_RUN_SC3);
      if (in_unit) begin
        if (b == 8'h00) begin
          // A fourth zero pushes the oldest pending zero into the data.
          if (pending_zeros >= ZERO_RUN_MAX) begin
            accept_data(8'h00);
          end else begin
            pending_zeros = pending_zeros + 2'd1;
          end
        end else if (is_code) begin
          close_unit();
          pending_zeros = '0;
        end else begin
          flush_pending_zeros();
          accept_data(b);
        end
        if (last) begin
          flush_pending_zeros();
          close_unit();
        end
      end else begin
        if (b == 8'h00) begin
          if (pending_zeros < ZERO_RUN_MAX) begin
            pending_zeros = pending_zeros + 2'd1;
          end
        end else if (is_code) begin
          in_unit       = 1'b1;
          unit_len      = LEN_NONE;
          pending_zeros = '0;
        end else begin
          pending_zeros = '0;
        end
      end
      // The final byte of a buffer clears the scanner.
      if (last) begin
        in_unit       = 1'b0;
        pending_zeros = '0;
        unit_len      = LEN_NONE;
        held_byte     = '0;
        hdr           = '0;
      end
    endfunction

    // Compare one output transaction with the oldest expected byte.
    function void check_result(logic [23:0] data, logic first, logic last);
      nal_result_t exp_r;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output transaction: data=%h first=%b last=%b", data, first, last);
        mismatches++;
        return;
      end
      exp_r = expected_bytes.pop_front();
      if (data[7:0] !== exp_r.nal_byte) begin
        $error("nal_byte: expected %h, actual %h", exp_r.nal_byte, data[7:0]);
        mismatches++;
      end
      if (first !== exp_r.first_of_nal) begin
        $error("first_of_nal: expected %b, actual %b", exp_r.first_of_nal, first);
        mismatches++;
      end
      if (last !== exp_r.end_of_nal) begin
        $error("end_of_nal: expected %b, actual %b", exp_r.end_of_nal, last);
        mismatches++;
      end
      if (data[13:8] !== exp_r.unit_type) begin
        $error("unit_type: expected %0d, actual %0d", exp_r.unit_type, data[13:8]);
        mismatches++;
      end
      if (data[19:14] !== exp_r.layer_number) begin
        $error("layer_number: expected %0d, actual %0d", exp_r.layer_number, data[19:14]);
        mismatches++;
      end
      if (data[23:20] !== exp_r.temporal_level) begin
        $error("temporal_level: expected %0d, actual %0d",
               $signed(exp_r.temporal_level), $signed(data[23:20]));
        mismatches++;
      end
    endfunction

  endclass

endpackage

`default_nettype wire

/* sim/tb_top.sv */
// Top-level testbench for the Annex B NAL splitter: stimulus, handshake drivers and watchdog.
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import nal_sb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 400;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH_IDLE,
    PH_BACKPRESSURE
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  phase_t       phase = PH_STEADY;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  stream_byte_t stim_q[$];
  nal_scoreboard sb = new();

  annexb_nal_splitter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queue one buffer; its final byte carries the end-of-buffer mark.
  function automatic void add_buffer(logic [7:0] bytes[$]);
    stream_byte_t sbyte;
    foreach (bytes[i]) begin
      sbyte.byte_value    = bytes[i];
      sbyte.end_of_buffer = (i == bytes.size() - 1);
      stim_q = {stim_q, sbyte};
    end
  endfunction

  // Payload bytes lean toward zeros and start bytes to hit the start-code logic.
  function automatic logic [7:0] pick_payload_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'h00;
    if (r == 3) return 8'h01;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed buffers of NAL units, with some plain noise buffers.
  function automatic void add_random_buffer();
    logic [7:0] bytes[$];
    int         units;
    int         len;
    int         zeros;
    if ($urandom_range(0, 4) == 0) begin
      len = $urandom_range(1, 12);
      repeat (len) bytes = {bytes, pick_payload_byte()};
    end else begin
      repeat ($urandom_range(0, 3)) bytes = {bytes, pick_payload_byte()};
      units = $urandom_range(1, 4);
      repeat (units) begin
        zeros = ($urandom_range(0, 9) < 6) ? 2 : $urandom_range(3, 4);
        repeat (zeros) bytes = {bytes, 8'h00};
        bytes = {bytes, 8'h01};
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
        repeat (len) bytes = {bytes, pick_payload_byte()};
      end
      // Sometimes the buffer ends on a start code.
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(2, 3)) bytes = {bytes, 8'h00};
        bytes = {bytes, 8'h01};
      end
    end
    add_buffer(bytes);
  endfunction

  // Drive every queued byte, one input transaction each; starts and ends at a falling edge.
  task automatic send_queued();
    stream_byte_t item;
    while (stim_q.size() > 0) begin
      item = stim_q.pop_front();
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= item.byte_value;
      in_tlast  <= item.end_of_buffer;
      do @(posedge clk); while (!in_tready);
      sb.note_input(item.byte_value, item.end_of_buffer);
      @(negedge clk);
    end
    in_tvalid <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off when the backpressure phase opens.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (phase == PH_BACKPRESSURE && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Check each output transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // Watchdog: too many cycles with no transaction on either side ends the run.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed buffers, then random buffers in each phase.
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A 3-byte start code on the final byte is only data: nothing comes out.
    add_buffer('{8'h00, 8'h00, 8'h01});
    // Extra leading zero stays in the unit; the last byte releases five results, filling the result queue.
    add_buffer('{8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                 8'h12, 8'h56, 8'h00, 8'h00, 8'h00, 8'h34});
    // A 4-byte start code on the final byte ends a one-byte unit, which is dropped.
    add_buffer('{8'h00, 8'h00, 8'h00, 8'h01, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h01});

    for (int p = PH_STEADY; p <= PH_BACKPRESSURE; p++) begin
      @(posedge clk);
      phase = phase_t'(p);
      case (phase)
        PH_SEND_GAPS: begin
          send_idle_pct  = 49;
          recv_stall_pct = 0;
        end
        PH_RECV_STALLS: begin
          send_idle_pct  = 0;
          recv_stall_pct = 49;
        end
        PH_BOTH_IDLE: begin
          send_idle_pct  = 14;
          recv_stall_pct = 14;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (stim_q.size() < ITEMS_PER_PHASE) add_random_buffer();
      @(negedge clk);
      send_queued();
    end

    // Drain the remaining predictions, then watch a little longer for strays.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
